// ===== rtl/core/fde_pkg.sv =====
// ----------------------------------------------------------------------------
// FAT directory entry parser package
// Shared codes and constants for the directory entry parser.
// ----------------------------------------------------------------------------
package fde_pkg;

    localparam logic [7:0]  ENTRY_END      = 8'h00;
    localparam logic [7:0]  ENTRY_DELETED  = 8'hE5;
    localparam logic [7:0]  ATTR_LONG_NAME = 8'h0F;
    localparam logic [7:0]  ORD_MASK       = 8'h3F;
    localparam logic [7:0]  ORD_LAST       = 8'h40;
    localparam logic [7:0]  ATTR_VOLUME    = 8'h08;
    localparam logic [7:0]  ATTR_DIR       = 8'h10;
    localparam logic [15:0] CHAR_FILL      = 16'hFFFF;
    localparam logic [7:0]  ASCII_SPACE    = 8'h20;
    localparam logic [7:0]  ASCII_DOT      = 8'h2E;
    localparam logic [7:0]  ASCII_QMARK    = 8'h3F;
    localparam int          LFN_CHARS      = 13;
    localparam int          MAX_NAME       = 255;
    // Store positions written by long-name entries reach 63*13.
    localparam int          POS_W          = 10;

    localparam logic        KIND_CHUNK     = 1'b0;
    localparam logic        KIND_END       = 1'b1;

    typedef logic [255:0] t_entry;

    // Byte offset of each UTF-16 character inside a long-name entry.
    function automatic logic [4:0] lfn_offset(input logic [3:0] idx);
        logic [4:0] off;
        case (idx)
            4'd0:    off = 5'd1;
            4'd1:    off = 5'd3;
            4'd2:    off = 5'd5;
            4'd3:    off = 5'd7;
            4'd4:    off = 5'd9;
            4'd5:    off = 5'd14;
            4'd6:    off = 5'd16;
            4'd7:    off = 5'd18;
            4'd8:    off = 5'd20;
            4'd9:    off = 5'd22;
            4'd10:   off = 5'd24;
            4'd11:   off = 5'd28;
            4'd12:   off = 5'd30;
            default: off = 5'd1;
        endcase
        return off;
    endfunction

endpackage

// ===== rtl/core/fde_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/fat_directory_entry_parser.sv =====
// ----------------------------------------------------------------------------
// FAT directory entry parser
// Parses 32-byte directory entries and reports found names as 8-byte chunks.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one transaction per directory entry as
// four little-endian 64-bit words, or a begin-directory action. The output
// channel carries name chunks of regular entries and one end-of-directory
// result. Both use valid and stall; a transaction moves when valid is high
// and stall is low.
// The parser handles one entry at a time and stalls its input while busy.
// A long-name entry stores its characters one at a time and then, for the
// last entry of a set, the terminator, limited by the single write port of
// the name store. A regular entry with a long name reads the store one
// character at a time, each read waiting for the registered store output,
// until it finds the end of the name; an 8.3 name is sent as one or two
// chunks. End, deleted and volume-label entries store and read no name.
// Results sit in an output register, so the first result appears the cycle
// after it is formed. While the receiver stalls, the result holds and the
// parser waits. Reset clears the pending-name flag, the entry count and the
// end flag; the name store is not cleared.
// ----------------------------------------------------------------------------
module fat_directory_entry_parser #(
    parameter int NAME_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [63:0] i_bytes_0_7,
    input  logic [63:0] i_bytes_8_15,
    input  logic [63:0] i_bytes_16_23,
    input  logic [63:0] i_bytes_24_31,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [63:0] o_name_chunk,
    output logic        o_last,
    output logic [31:0] o_size_bytes,
    output logic [31:0] o_start_cluster,
    output logic        o_is_directory,
    output logic [16:0] o_found_count
);

    localparam int AW    = $clog2(NAME_BYTES);
    localparam int LIMIT = (NAME_BYTES < fde_pkg::MAX_NAME) ? NAME_BYTES : fde_pkg::MAX_NAME;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LFN   = 3'd1;
    localparam logic [2:0] S_TERM  = 3'd2;
    localparam logic [2:0] S_LRD   = 3'd3;
    localparam logic [2:0] S_LWT   = 3'd4;
    localparam logic [2:0] S_SHORT = 3'd5;
    localparam logic [2:0] S_ENDR  = 3'd6;

    // Formats the 8.3 name; bit 96 flags a name longer than one chunk.
    function automatic logic [96:0] short_name(input fde_pkg::t_entry w);
        logic [7:0]  nm [12];
        logic [3:0]  len;
        logic [3:0]  k;
        logic        stop;
        logic        hit;
        logic [7:0]  b;
        logic [95:0] flat;
        for (int j = 0; j < 12; j++) begin
            nm[j] = 8'h00;
        end
        len  = 4'd0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            b = w[i*8 +: 8];
            if (!stop && b != fde_pkg::ASCII_SPACE) begin
                nm[len] = b;
                len     = len + 4'd1;
            end else begin
                stop = 1'b1;
            end
        end
        if (w[64 +: 8] != fde_pkg::ASCII_SPACE) begin
            nm[len] = fde_pkg::ASCII_DOT;
            len     = len + 4'd1;
            stop    = 1'b0;
            for (int i = 8; i < 11; i++) begin
                b = w[i*8 +: 8];
                if (!stop && b != fde_pkg::ASCII_SPACE) begin
                    nm[len] = b;
                    len     = len + 4'd1;
                end else begin
                    stop = 1'b1;
                end
            end
        end
        k   = len;
        hit = 1'b0;
        for (int j = 0; j < 12; j++) begin
            if (!hit && 4'(j) < len && nm[j] == 8'h00) begin
                k   = 4'(j);
                hit = 1'b1;
            end
        end
        for (int j = 0; j < 12; j++) begin
            flat[j*8 +: 8] = (4'(j) < k) ? nm[j] : 8'h00;
        end
        return {(k > 4'd8), flat};
    endfunction

    logic [2:0]           r_state, n_state;
    logic                 r_pending, n_pending;
    logic [16:0]          r_seen, n_seen;
    logic                 r_ended, n_ended;
    fde_pkg::t_entry      r_w, n_w;
    logic [3:0]           r_ci, n_ci;
    logic [fde_pkg::POS_W-1:0] r_pos, n_pos;
    logic [3:0]           r_nb, n_nb;
    logic [63:0]          r_chunk, n_chunk;
    logic                 r_sidx, n_sidx;

    logic                 r_ovalid, n_ovalid;
    logic                 r_kind, n_kind;
    logic [63:0]          r_oname, n_oname;
    logic                 r_olast, n_olast;
    logic [31:0]          r_osize, n_osize;
    logic [31:0]          r_oclus, n_oclus;
    logic                 r_odir, n_odir;
    logic [16:0]          r_ocount, n_ocount;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [7:0]           mem_wdata;
    logic                 mem_re;
    logic [7:0]           mem_rdata;

    fde_pkg::t_entry      in_w;
    logic                 in_acc;
    logic                 can_emit;
    logic [7:0]           first;
    logic [7:0]           attr;
    logic [5:0]           ord;
    logic [4:0]           coff;
    logic [15:0]          ch;
    logic [96:0]          sname;
    logic [fde_pkg::POS_W-1:0] term_pos;

    assign in_w     = {i_bytes_24_31, i_bytes_16_23, i_bytes_8_15, i_bytes_0_7};
    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign can_emit = !r_ovalid || !i_out_stall;
    assign first    = in_w[7:0];
    assign attr     = in_w[95:88];
    assign ord      = r_w[5:0];
    assign coff     = fde_pkg::lfn_offset(r_ci);
    assign ch       = r_w[{coff, 3'b000} +: 16];
    assign sname    = short_name(r_w);
    assign term_pos = fde_pkg::POS_W'({4'd0, ord} * 10'd13);

    fde_ram #(
        .WIDTH (8),
        .DEPTH (NAME_BYTES)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_pos[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        n_seen    = r_seen;
        n_ended   = r_ended;
        n_w       = r_w;
        n_ci      = r_ci;
        n_pos     = r_pos;
        n_nb      = r_nb;
        n_chunk   = r_chunk;
        n_sidx    = r_sidx;
        n_ovalid  = r_ovalid && i_out_stall;
        n_kind    = r_kind;
        n_oname   = r_oname;
        n_olast   = r_olast;
        n_osize   = r_osize;
        n_oclus   = r_oclus;
        n_odir    = r_odir;
        n_ocount  = r_ocount;
        mem_we    = 1'b0;
        mem_waddr = r_pos[AW-1:0];
        mem_wdata = 8'h00;
        mem_re    = 1'b0;

        // Size, cluster and directory flag come from the held entry, loaded
        // only while the output register is free so a stalled result holds.
        if (can_emit && (r_state == S_LRD || r_state == S_LWT || r_state == S_SHORT)) begin
            n_osize = r_w[255:224];
            n_oclus = {r_w[175:160], r_w[223:208]};
            n_odir  = |(r_w[95:88] & fde_pkg::ATTR_DIR);
            n_kind  = fde_pkg::KIND_CHUNK;
            n_ocount = r_seen;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_w = in_w;
                    if (i_action) begin
                        n_pending = 1'b0;
                        n_seen    = 17'd0;
                        n_ended   = 1'b0;
                    end else if (r_ended) begin
                        n_state = S_IDLE;
                    end else if (first == fde_pkg::ENTRY_END) begin
                        n_ended = 1'b1;
                        n_state = S_ENDR;
                    end else if (first == fde_pkg::ENTRY_DELETED) begin
                        n_pending = 1'b0;
                    end else if (attr == fde_pkg::ATTR_LONG_NAME) begin
                        n_pending = 1'b1;
                        n_ci      = 4'd0;
                        n_pos     = fde_pkg::POS_W'(({4'd0, first[5:0]} - 10'd1) * 10'd13);
                        n_state   = (first[5:0] == 6'd0) ? S_TERM : S_LFN;
                    end else if (|(attr & fde_pkg::ATTR_VOLUME)) begin
                        n_pending = 1'b0;
                    end else begin
                        if (r_seen != 17'h10000) begin
                            n_seen = r_seen + 17'd1;
                        end
                        n_pending = 1'b0;
                        n_pos     = '0;
                        n_nb      = 4'd0;
                        n_chunk   = 64'd0;
                        n_sidx    = 1'b0;
                        n_state   = r_pending ? S_LRD : S_SHORT;
                    end
                end
            end
            S_LFN: begin
                // One character per cycle; a null or fill character ends it.
                mem_we = ({22'd0, r_pos} < NAME_BYTES);
                if (ch == 16'h0000 || ch == fde_pkg::CHAR_FILL) begin
                    mem_wdata = 8'h00;
                    n_state   = S_TERM;
                end else begin
                    mem_wdata = ch[15:7] == 9'd0 ? ch[7:0] : fde_pkg::ASCII_QMARK;
                    n_pos     = r_pos + 1'b1;
                    n_ci      = r_ci + 4'd1;
                    if (32'(r_ci) == fde_pkg::LFN_CHARS - 1) begin
                        n_state = S_TERM;
                    end
                end
            end
            S_TERM: begin
                // The last long-name entry of a set also marks the name end.
                mem_waddr = term_pos[AW-1:0];
                mem_we    = |(r_w[7:0] & fde_pkg::ORD_LAST) && ({22'd0, term_pos} < NAME_BYTES);
                n_state   = S_IDLE;
            end
            S_LRD: begin
                if (32'(r_pos) == LIMIT) begin
                    if (can_emit) begin
                        n_ovalid = 1'b1;
                        n_oname  = r_chunk;
                        n_olast  = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_LWT;
                end
            end
            S_LWT: begin
                // A full chunk is held back until the next character shows
                // whether it is the last one.
                if (mem_rdata == 8'h00) begin
                    if (can_emit) begin
                        n_ovalid = 1'b1;
                        n_oname  = r_chunk;
                        n_olast  = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else if (r_nb == 4'd8) begin
                    if (can_emit) begin
                        n_ovalid = 1'b1;
                        n_oname  = r_chunk;
                        n_olast  = 1'b0;
                        n_chunk  = {56'd0, mem_rdata};
                        n_nb     = 4'd1;
                        n_pos    = r_pos + 1'b1;
                        n_state  = S_LRD;
                    end
                end else begin
                    n_chunk[{r_nb[2:0], 3'b000} +: 8] = mem_rdata;
                    n_nb    = r_nb + 4'd1;
                    n_pos   = r_pos + 1'b1;
                    n_state = S_LRD;
                end
            end
            S_SHORT: begin
                if (can_emit) begin
                    n_ovalid = 1'b1;
                    if (!r_sidx) begin
                        n_oname = sname[63:0];
                        n_olast = !sname[96];
                        n_sidx  = 1'b1;
                        n_state = sname[96] ? S_SHORT : S_IDLE;
                    end else begin
                        n_oname = {32'd0, sname[95:64]};
                        n_olast = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_ENDR: begin
                if (can_emit) begin
                    n_ovalid = 1'b1;
                    n_kind   = fde_pkg::KIND_END;
                    n_oname  = 64'd0;
                    n_olast  = 1'b1;
                    n_osize  = 32'd0;
                    n_oclus  = 32'd0;
                    n_odir   = 1'b0;
                    n_ocount = r_seen;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pending <= 1'b0;
            r_seen    <= 17'd0;
            r_ended   <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_seen    <= n_seen;
            r_ended   <= n_ended;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w      <= n_w;
        r_ci     <= n_ci;
        r_pos    <= n_pos;
        r_nb     <= n_nb;
        r_chunk  <= n_chunk;
        r_sidx   <= n_sidx;
        r_kind   <= n_kind;
        r_oname  <= n_oname;
        r_olast  <= n_olast;
        r_osize  <= n_osize;
        r_oclus  <= n_oclus;
        r_odir   <= n_odir;
        r_ocount <= n_ocount;
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_ovalid;
    assign o_kind          = r_kind;
    assign o_name_chunk    = r_oname;
    assign o_last          = r_olast;
    assign o_size_bytes    = r_osize;
    assign o_start_cluster = r_oclus;
    assign o_is_directory  = r_odir;
    assign o_found_count   = r_ocount;

endmodule

// ===== dv/fat_directory_entry_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FAT directory entry parser testbench
// Drives directory entries, long-name sets and short-name entries through the
// parser and checks every name chunk and end-of-directory result against a
// behavioral predictor of the parser.
// ----------------------------------------------------------------------------
module fat_directory_entry_parser_tb;

    localparam int NAME_BYTES = 256;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic        action;
        logic [63:0] w0, w1, w2, w3;
    } t_item;

    typedef struct {
        logic        kind;
        logic [63:0] chunk;
        logic        last;
        logic [31:0] size;
        logic [31:0] clus;
        logic        isdir;
        logic [16:0] count;
    } t_report;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic action = 1'b0;
    logic [63:0] b0 = '0, b1 = '0, b2 = '0, b3 = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic kind, last, isdir;
    logic [63:0] chunk;
    logic [31:0] fsize, clus;
    logic [16:0] count;

    // Whether the entry on the bus was left waiting at the last rising edge.
    logic in_stall_q = 1'b1;

    fat_directory_entry_parser #(.NAME_BYTES(NAME_BYTES)) dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_action(action), .i_bytes_0_7(b0), .i_bytes_8_15(b1),
        .i_bytes_16_23(b2), .i_bytes_24_31(b3), .o_out_valid(out_valid),
        .i_out_stall(out_stall), .o_kind(kind), .o_name_chunk(chunk), .o_last(last),
        .o_size_bytes(fsize), .o_start_cluster(clus), .o_is_directory(isdir),
        .o_found_count(count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state mirrors the parser's visible state.
    logic [7:0]  name_store [NAME_BYTES];
    logic        name_pending;
    logic [16:0] seen_count;
    logic        dir_ended;

    t_item   pending_entries[$];
    t_report expected_reports[$];
    int      failures = 0;
    int      cycles = 0;
    int      send_idle_pct = 12;
    int      recv_idle_pct = 86;
    bit      hold_sender = 1'b0;

    function automatic logic [7:0] byte_at(t_item e, int i);
        logic [255:0] all;
        all = {e.w3, e.w2, e.w1, e.w0};
        return all[i*8 +: 8];
    endfunction

    // Applies one accepted entry to the predictor and queues its results.
    task automatic predict_entry(t_item e);
        logic [7:0] first, attr, b;
        logic [7:0] nm [256];
        logic [15:0] ch;
        logic [31:0] fs, cl;
        int ord, pos, len, nchunks, off;
        t_report r;
        bit stop;
        for (int i = 0; i < 256; i++) nm[i] = 8'h00;
        if (e.action) begin
            name_pending = 1'b0;
            seen_count = '0;
            dir_ended = 1'b0;
            return;
        end
        if (dir_ended) return;
        first = byte_at(e, 0);
        attr = byte_at(e, 11);
        if (first == fde_pkg::ENTRY_END) begin
            dir_ended = 1'b1;
            r = '{fde_pkg::KIND_END, 64'd0, 1'b1, 32'd0, 32'd0, 1'b0, seen_count};
            expected_reports.push_back(r);
            return;
        end
        if (first == fde_pkg::ENTRY_DELETED) begin
            name_pending = 1'b0;
            return;
        end
        if (attr == fde_pkg::ATTR_LONG_NAME) begin
            ord = first & fde_pkg::ORD_MASK;
            if (ord != 0) begin
                pos = (ord - 1) * fde_pkg::LFN_CHARS;
                for (int i = 0; i < fde_pkg::LFN_CHARS; i++) begin
                    off = fde_pkg::lfn_offset(i[3:0]);
                    ch = {byte_at(e, off + 1), byte_at(e, off)};
                    if (ch == 16'h0000 || ch == fde_pkg::CHAR_FILL) begin
                        if (pos < NAME_BYTES) name_store[pos] = 8'h00;
                        break;
                    end
                    if (pos < NAME_BYTES)
                        name_store[pos] = (ch < 16'd128) ? ch[7:0] : fde_pkg::ASCII_QMARK;
                    pos++;
                end
            end
            if ((first & fde_pkg::ORD_LAST) != 0 && ord * fde_pkg::LFN_CHARS < NAME_BYTES)
                name_store[ord * fde_pkg::LFN_CHARS] = 8'h00;
            name_pending = 1'b1;
            return;
        end
        if ((attr & fde_pkg::ATTR_VOLUME) != 0) begin
            name_pending = 1'b0;
            return;
        end
        len = 0;
        if (name_pending) begin
            while (len < fde_pkg::MAX_NAME && len < NAME_BYTES && name_store[len] != 8'h00) begin
                nm[len] = name_store[len];
                len++;
            end
        end else begin
            for (int i = 0; i < 8; i++) begin
                b = byte_at(e, i);
                if (b == fde_pkg::ASCII_SPACE) break;
                nm[len++] = b;
            end
            if (byte_at(e, 8) != fde_pkg::ASCII_SPACE) begin
                nm[len++] = fde_pkg::ASCII_DOT;
                for (int i = 8; i < 11; i++) begin
                    b = byte_at(e, i);
                    if (b == fde_pkg::ASCII_SPACE) break;
                    nm[len++] = b;
                end
            end
            // A zero byte inside the short name ends it.
            stop = 1'b0;
            for (int k = 0; k < 12; k++) begin
                if (nm[k] == 8'h00) stop = 1'b1;
                if (stop) nm[k] = 8'h00;
            end
            len = 0;
            while (len < 12 && nm[len] != 8'h00) len++;
        end
        name_pending = 1'b0;
        if (seen_count < 17'd65536) seen_count++;
        fs = {byte_at(e, 31), byte_at(e, 30), byte_at(e, 29), byte_at(e, 28)};
        cl = {byte_at(e, 21), byte_at(e, 20), byte_at(e, 27), byte_at(e, 26)};
        nchunks = (len + 7) / 8;
        if (nchunks == 0) nchunks = 1;
        for (int k = 0; k < nchunks; k++) begin
            r.kind = fde_pkg::KIND_CHUNK;
            r.chunk = '0;
            for (int j = 0; j < 8; j++) r.chunk[j*8 +: 8] = nm[k*8 + j];
            r.last = (k + 1 == nchunks);
            r.size = fs;
            r.clus = cl;
            r.isdir = (attr & fde_pkg::ATTR_DIR) != 0;
            r.count = seen_count;
            expected_reports.push_back(r);
        end
    endtask

    // Driver: presents the next pending entry at the falling edge.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || !in_stall_q) begin
                if (pending_entries.size() > 0 && !hold_sender
                        && $urandom_range(99) >= send_idle_pct) begin
                    action <= pending_entries[0].action;
                    b0 <= pending_entries[0].w0;
                    b1 <= pending_entries[0].w1;
                    b2 <= pending_entries[0].w2;
                    b3 <= pending_entries[0].w3;
                    in_valid <= 1'b1;
                    void'(pending_entries.pop_front());
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor: predicts on input acceptance and checks results.
    always @(posedge clk) begin
        t_report x;
        cycles <= cycles + 1;
        in_stall_q <= in_valid && in_stall;
        if (rst_n && in_valid && !in_stall)
            predict_entry('{action, b0, b1, b2, b3});
        if (rst_n && out_valid && !out_stall) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected result: chunk %h", chunk);
                failures++;
            end else begin
                x = expected_reports.pop_front();
                if (kind !== x.kind) begin
                    $error("kind: expected %0d actual %0d", x.kind, kind); failures++;
                end
                if (chunk !== x.chunk) begin
                    $error("name_chunk: expected %h actual %h", x.chunk, chunk); failures++;
                end
                if (last !== x.last) begin
                    $error("last: expected %0d actual %0d", x.last, last); failures++;
                end
                if (fsize !== x.size) begin
                    $error("size_bytes: expected %h actual %h", x.size, fsize); failures++;
                end
                if (clus !== x.clus) begin
                    $error("start_cluster: expected %h actual %h", x.clus, clus);
                    failures++;
                end
                if (isdir !== x.isdir) begin
                    $error("is_directory: expected %0d actual %0d", x.isdir, isdir);
                    failures++;
                end
                if (count !== x.count) begin
                    $error("found_count: expected %0d actual %0d", x.count, count);
                    failures++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_item make_entry(logic [255:0] raw);
        return '{1'b0, raw[63:0], raw[127:64], raw[191:128], raw[255:192]};
    endfunction

    // Builds a long-name entry with ordinal byte ord_b and 13 characters.
    function automatic t_item make_lfn(logic [7:0] ord_b, logic [15:0] chars [13]);
        logic [255:0] raw;
        int off;
        raw = {$urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
        raw[7:0] = ord_b;
        raw[95:88] = fde_pkg::ATTR_LONG_NAME;
        for (int i = 0; i < 13; i++) begin
            off = fde_pkg::lfn_offset(i[3:0]);
            raw[off*8 +: 16] = chars[i];
        end
        return make_entry(raw);
    endfunction

    // A regular short entry with random bytes; names may hold spaces and zeros.
    function automatic t_item make_short();
        logic [255:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
        for (int i = 0; i < 11; i++) begin
            case ($urandom_range(5))
                0: raw[i*8 +: 8] = fde_pkg::ASCII_SPACE;
                1: raw[i*8 +: 8] = 8'(8'h41 + $urandom_range(25));
                default: ;
            endcase
        end
        if (raw[7:0] == fde_pkg::ENTRY_END || raw[7:0] == fde_pkg::ENTRY_DELETED)
            raw[7:0] = 8'h46;
        raw[95:88] = 8'($urandom) & ~8'h08;
        return make_entry(raw);
    endfunction

    // A long name of nseg segments (last segment first) followed by its entry.
    task automatic push_long_name(int nseg, bit broken);
        logic [15:0] chars [13];
        int cut;
        cut = $urandom_range(12);
        for (int s = nseg; s >= 1; s--) begin
            for (int i = 0; i < 13; i++) begin
                case ($urandom_range(9))
                    0: chars[i] = 16'($urandom);
                    1: chars[i] = 16'(16'h0080 + $urandom_range(16'hFF00));
                    default: chars[i] = 16'(16'h0021 + $urandom_range(16'h5D));
                endcase
                if (chars[i] == 16'h0000 || chars[i] == fde_pkg::CHAR_FILL)
                    chars[i] = 16'h0041;
            end
            if (s == nseg && $urandom_range(1)) begin
                chars[cut] = $urandom_range(1) ? 16'h0000 : fde_pkg::CHAR_FILL;
                for (int i = cut + 1; i < 13; i++) chars[i] = fde_pkg::CHAR_FILL;
            end
            pending_entries.push_back(make_lfn(
                8'((s == nseg ? fde_pkg::ORD_LAST : 8'h00) | s[7:0]
                   | ($urandom_range(1) << 7)), chars));
            if (broken && s == 2) pending_entries.push_back(make_short());
        end
        pending_entries.push_back(make_short());
    endtask

    task automatic wait_drained();
        while (pending_entries.size() > 0 || in_valid || expected_reports.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    initial begin
        logic [15:0] chars [13];
        logic [255:0] raw;
        t_item e;
        name_pending = 1'b0;
        seen_count = '0;
        dir_ended = 1'b0;
        for (int i = 0; i < NAME_BYTES; i++) name_store[i] = 8'h00;
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed part. The name store is first filled with a full-length
        // name so that later long names never read unwritten entries.
        for (int i = 0; i < 13; i++) chars[i] = 16'(16'h0061 + i);
        for (int s = 20; s >= 1; s--)
            pending_entries.push_back(
                make_lfn((s == 20 ? fde_pkg::ORD_LAST : 8'h00) | s[7:0], chars));
        raw = '0; raw[63:0] = "ABCDEFGH"; raw[95:64] = {8'h10, "TXT"};
        raw[255:224] = 32'hFFFFFFFF; raw[175:160] = 16'hFFFF; raw[223:208] = 16'hFFFF;
        pending_entries.push_back(make_entry(raw));     // longest name, 32 chunks
        raw = '1; raw[7:0] = 8'h41; raw[95:88] = 8'h30;
        pending_entries.push_back(make_entry(raw));     // all-ones short entry
        raw = '0; raw[7:0] = 8'h42; raw[95:64] = {8'h00, "   "};
        pending_entries.push_back(make_entry(raw));     // short name ended by a zero
        raw = {256{1'b0}}; raw[63:0] = {8{fde_pkg::ASCII_SPACE}}; raw[7:0] = 8'h43;
        raw[63:8] = {7{fde_pkg::ASCII_SPACE}}; raw[95:64] = {8'h20, "   "};
        pending_entries.push_back(make_entry(raw));     // base only, no extension
        for (int i = 0; i < 13; i++) chars[i] = (i == 3) ? 16'h00E9 : 16'(16'h0041 + i);
        pending_entries.push_back(make_lfn(fde_pkg::ORD_LAST | 8'd1, chars));
        raw = '0; raw[7:0] = fde_pkg::ENTRY_DELETED;   // deleted entry drops it
        pending_entries.push_back(make_entry(raw));
        pending_entries.push_back(make_short());
        pending_entries.push_back(make_lfn(fde_pkg::ORD_LAST, chars));  // ordinal zero
        pending_entries.push_back(make_short());        // empty long name
        pending_entries.push_back(make_lfn(fde_pkg::ORD_LAST | 8'd1, chars));
        raw = '0; raw[7:0] = 8'h56; raw[95:88] = fde_pkg::ATTR_VOLUME;   // volume label
        pending_entries.push_back(make_entry(raw));
        pending_entries.push_back(make_short());
        pending_entries.push_back(make_lfn(fde_pkg::ORD_LAST | 8'd63, chars));  // beyond store
        pending_entries.push_back(make_short());
        raw = '0;
        pending_entries.push_back(make_entry(raw));     // end of directory
        pending_entries.push_back(make_short());        // ignored after end
        pending_entries.push_back('{1'b1, '0, '0, '0, '0});
        wait_drained();

        // Random part in three idling phases.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 86 : 0;
            recv_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 12 : 0;
            repeat (26) begin
                case ($urandom_range(9))
                    0, 1, 2: push_long_name($urandom_range(1, 3), 1'b0);
                    3: push_long_name($urandom_range(1, 4), 1'b1);
                    4, 5: pending_entries.push_back(make_short());
                    6: begin
                        raw = {rand64(), rand64(), rand64(), rand64()};
                        if ($urandom_range(3) == 0) raw[7:0] = fde_pkg::ENTRY_DELETED;
                        pending_entries.push_back(make_entry(raw));
                    end
                    7: begin
                        raw = {rand64(), rand64(), rand64(), rand64()};
                        raw[7:0] = fde_pkg::ENTRY_END;
                        pending_entries.push_back(make_entry(raw));
                        pending_entries.push_back(make_short());
                        e = '{1'b1, rand64(), rand64(), rand64(), rand64()};
                        pending_entries.push_back(e);
                    end
                    8: begin
                        raw = {rand64(), rand64(), rand64(), rand64()};
                        raw[7:0] = 8'h56; raw[91] = 1'b1; raw[95:88] |= 8'h30;
                        pending_entries.push_back(make_entry(raw));
                    end
                    default: begin
                        for (int i = 0; i < 13; i++) chars[i] = 16'($urandom);
                        pending_entries.push_back(make_lfn(8'($urandom), chars));
                        pending_entries.push_back(make_short());
                    end
                endcase
                if ($urandom_range(5) == 0) begin
                    // Hold off the sender until every result has arrived.
                    while (pending_entries.size() > 0 || in_valid) @(posedge clk);
                    hold_sender = 1'b1;
                    while (expected_reports.size() > 0) @(posedge clk);
                    hold_sender = 1'b0;
                end
            end
            wait_drained();
        end

        if (failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== fat_directory_entry_parser.f =====
rtl/core/fde_pkg.sv
rtl/core/fde_ram.sv
rtl/core/fat_directory_entry_parser.sv
dv/fat_directory_entry_parser_tb.sv
